// ----- rtl/tqcg_pkg.sv -----
package tqcg_pkg;

   localparam int ID_W        = 16;
   localparam int COLS_W      = 8;
   localparam int DIM_W       = 9;
   localparam int NUM_ENTRIES = 4;
   localparam int DIV_STEP    = 4;
   localparam int DIV_STAGES  = ID_W / DIV_STEP;

   typedef enum logic [2:0] {
      REG_MAP_COLUMNS   = 3'd0,
      REG_MAP_ROWS      = 3'd1,
      REG_MAP_CELL_SIZE = 3'd2,
      REG_TILESET_COUNT = 3'd3,
      REG_TILESET_0     = 3'd4,
      REG_TILESET_1     = 3'd5,
      REG_TILESET_2     = 3'd6,
      REG_TILESET_3     = 3'd7
   } reg_index_type;

   // packed as in the register: first id in the low half-word
   typedef struct packed {
      logic [7:0]        tile_h;
      logic [7:0]        tile_w;
      logic [COLS_W-1:0] columns;
      logic [ID_W-1:0]   first_id;
   } tileset_type;

   // quotient bits shift into quo from the bottom as dividend bits leave the top
   typedef struct packed {
      logic [ID_W-1:0]   quo;
      logic [COLS_W-1:0] rem;
      logic [COLS_W-1:0] divisor;
   } div_type;

   typedef struct packed {
      logic [7:0]       x;
      logic [7:0]       y;
      logic [2:0]       layer;
      logic [7:0]       alpha;
      logic [1:0]       sel;
      logic [DIM_W-1:0] cols;
      logic [17:0]      cols_rows;
      logic [7:0]       cell_w;
      logic [7:0]       cell_h;
      logic [7:0]       tile_w;
      logic [7:0]       tile_h;
   } item_type;

endpackage

// ----- rtl/tile_quad_coordinate_generator.sv -----
// Path: the front stage, the divider stages, the multiply stage and the output stage, each registered, in that order.
// Throughput: one word per cycle; busy is never raised, the receiver cannot stall.
// Depth is set by the 16-bit tile id divider, 4 quotient bits per stage over 4 stages.
// Synchronous reset clears all pipeline valid bits and loads the register reset values.
module tile_quad_coordinate_generator #(
   parameter int MAX_TILESETS = 4,
   parameter int MAX_MAP_DIM  = 256,
   parameter int MAX_LAYERS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_cell_x,
   input  logic [7:0]  req_cell_y,
   input  logic [2:0]  req_layer_number,
   input  logic [15:0] req_tile_id,
   input  logic [7:0]  req_layer_alpha,
   output logic        rsp_valid,
   output logic [20:0] rsp_vertex_slot,
   output logic [15:0] rsp_screen_left,
   output logic [15:0] rsp_screen_top,
   output logic [15:0] rsp_screen_right,
   output logic [15:0] rsp_screen_bottom,
   output logic [15:0] rsp_tex_left,
   output logic [23:0] rsp_tex_top,
   output logic [15:0] rsp_tex_right,
   output logic [23:0] rsp_tex_bottom,
   output logic [1:0]  rsp_tileset_index,
   output logic [7:0]  rsp_vertex_alpha,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import tqcg_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]  map_columns_ff, map_columns_in;
   logic [DIM_W-1:0]  map_rows_ff, map_rows_in;
   logic [15:0]       map_cell_size_ff, map_cell_size_in;
   logic [2:0]        tileset_count_ff, tileset_count_in;
   tileset_type       tileset_ff [NUM_ENTRIES];
   tileset_type       tileset_in [NUM_ENTRIES];
   logic              csr_write;
   reg_index_type     csr_index;

   // front stage and divider stages
   logic              dv_ff [DIV_STAGES+1];
   logic              dv_in [DIV_STAGES+1];
   div_type           div_ff [DIV_STAGES+1];
   div_type           div_in [DIV_STAGES+1];
   item_type          item_ff [DIV_STAGES+1];
   item_type          item_in [DIV_STAGES+1];

   // multiply stage
   logic              mv_ff, mv_in;
   item_type          mitem_ff, mitem_in;
   logic [15:0]       m_tex_l_ff, m_tex_l_in;
   logic [23:0]       m_tex_t_ff, m_tex_t_in;
   logic [15:0]       m_scr_l_ff, m_scr_l_in;
   logic [15:0]       m_scr_t_ff, m_scr_t_in;
   logic [16:0]       m_ycols_ff, m_ycols_in;
   logic [20:0]       m_lcr_ff, m_lcr_in;

   // output stage
   logic              ov_ff, ov_in;
   logic [20:0]       o_slot_ff, o_slot_in;
   logic [15:0]       o_scr_l_ff, o_scr_l_in;
   logic [15:0]       o_scr_t_ff, o_scr_t_in;
   logic [15:0]       o_scr_r_ff, o_scr_r_in;
   logic [15:0]       o_scr_b_ff, o_scr_b_in;
   logic [15:0]       o_tex_l_ff, o_tex_l_in;
   logic [23:0]       o_tex_t_ff, o_tex_t_in;
   logic [15:0]       o_tex_r_ff, o_tex_r_in;
   logic [23:0]       o_tex_b_ff, o_tex_b_in;
   logic [1:0]        o_sel_ff, o_sel_in;
   logic [7:0]        o_alpha_ff, o_alpha_in;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[5:3]);

   always_comb begin
      map_columns_in   = map_columns_ff;
      map_rows_in      = map_rows_ff;
      map_cell_size_in = map_cell_size_ff;
      tileset_count_in = tileset_count_ff;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         tileset_in[i] = tileset_ff[i];
      end
      if (csr_write) begin
         unique case (csr_index)
            REG_MAP_COLUMNS:   map_columns_in   = csr_pwdata[DIM_W-1:0];
            REG_MAP_ROWS:      map_rows_in      = csr_pwdata[DIM_W-1:0];
            REG_MAP_CELL_SIZE: map_cell_size_in = csr_pwdata[15:0];
            REG_TILESET_COUNT: tileset_count_in = csr_pwdata[2:0];
            REG_TILESET_0:     tileset_in[0]    = tileset_type'(csr_pwdata[39:0]);
            REG_TILESET_1:     tileset_in[1]    = tileset_type'(csr_pwdata[39:0]);
            REG_TILESET_2:     tileset_in[2]    = tileset_type'(csr_pwdata[39:0]);
            REG_TILESET_3:     tileset_in[3]    = tileset_type'(csr_pwdata[39:0]);
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MAP_COLUMNS:   csr_prdata = 64'(map_columns_ff);
         REG_MAP_ROWS:      csr_prdata = 64'(map_rows_ff);
         REG_MAP_CELL_SIZE: csr_prdata = 64'(map_cell_size_ff);
         REG_TILESET_COUNT: csr_prdata = 64'(tileset_count_ff);
         REG_TILESET_0:     csr_prdata = 64'(tileset_ff[0]);
         REG_TILESET_1:     csr_prdata = 64'(tileset_ff[1]);
         REG_TILESET_2:     csr_prdata = 64'(tileset_ff[2]);
         REG_TILESET_3:     csr_prdata = 64'(tileset_ff[3]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff   <= DIM_W'(1);
         map_rows_ff      <= DIM_W'(1);
         map_cell_size_ff <= 16'd257;
         tileset_count_ff <= 3'd0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            tileset_ff[i] <= '0;
         end
      end else begin
         map_columns_ff   <= map_columns_in;
         map_rows_ff      <= map_rows_in;
         map_cell_size_ff <= map_cell_size_in;
         tileset_count_ff <= tileset_count_in;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            tileset_ff[i] <= tileset_in[i];
         end
      end
   end

   // ------------------------------------------------------ front: tileset pick
   assign busy = 1'b0;

   always_comb begin
      logic [2:0]       count_lim;
      logic             found;
      logic [1:0]       sel;
      tileset_type      ent;
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] rows;
      logic [2:0]       layer;

      count_lim = (32'(tileset_count_ff) > MAX_TILESETS) ? 3'(MAX_TILESETS)
                                                           : tileset_count_ff;
      found = 1'b0;
      sel   = 2'd0;
      // ascending scan, so the highest qualifying entry wins
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if ((3'(i) < count_lim) && (tileset_ff[i].first_id <= req_tile_id)) begin
            found = 1'b1;
            sel   = 2'(i);
         end
      end
      ent = tileset_ff[sel];

      cols  = (32'(map_columns_ff) > MAX_MAP_DIM) ? DIM_W'(MAX_MAP_DIM) : map_columns_ff;
      rows  = (32'(map_rows_ff) > MAX_MAP_DIM) ? DIM_W'(MAX_MAP_DIM) : map_rows_ff;
      layer = (32'(req_layer_number) >= MAX_LAYERS) ? 3'(MAX_LAYERS - 1)
                                                    : req_layer_number;

      dv_in[0] = start & ~busy & (req_tile_id != '0) & found & (ent.columns != '0);

      div_in[0].quo     = req_tile_id - ent.first_id;
      div_in[0].rem     = '0;
      div_in[0].divisor = ent.columns;

      item_in[0].x         = req_cell_x;
      item_in[0].y         = req_cell_y;
      item_in[0].layer     = layer;
      item_in[0].alpha     = req_layer_alpha;
      item_in[0].sel       = sel;
      item_in[0].cols      = cols;
      item_in[0].cols_rows = 18'(cols) * 18'(rows);
      item_in[0].cell_w    = map_cell_size_ff[7:0];
      item_in[0].cell_h    = map_cell_size_ff[15:8];
      item_in[0].tile_w    = ent.tile_w;
      item_in[0].tile_h    = ent.tile_h;
   end

   // ------------------------------------------------------ divider stages
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      always_comb begin
         logic [ID_W-1:0]   q;
         logic [COLS_W-1:0] r;
         logic [COLS_W:0]   t;

         q = div_ff[g].quo;
         r = div_ff[g].rem;
         for (int k = 0; k < DIV_STEP; k++) begin
            t = {r, q[ID_W-1]};
            q = {q[ID_W-2:0], 1'b0};
            if (t >= {1'b0, div_ff[g].divisor}) begin
               r    = COLS_W'(t - {1'b0, div_ff[g].divisor});
               q[0] = 1'b1;
            end else begin
               r = t[COLS_W-1:0];
            end
         end
         dv_in[g+1]          = dv_ff[g];
         div_in[g+1].quo     = q;
         div_in[g+1].rem     = r;
         div_in[g+1].divisor = div_ff[g].divisor;
         item_in[g+1]        = item_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            dv_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            dv_ff[s] <= dv_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         div_ff[s]  <= div_in[s];
         item_ff[s] <= item_in[s];
      end
   end

   // ------------------------------------------------------ multiply stage
   always_comb begin
      item_type          it;
      logic [COLS_W-1:0] tu;
      logic [ID_W-1:0]   tv;

      it = item_ff[DIV_STAGES];
      tu = div_ff[DIV_STAGES].rem;
      tv = div_ff[DIV_STAGES].quo;

      mv_in      = dv_ff[DIV_STAGES];
      mitem_in   = it;
      m_tex_l_in = 16'(tu) * 16'(it.tile_w);
      m_tex_t_in = 24'(tv) * 24'(it.tile_h);
      m_scr_l_in = 16'(it.x) * 16'(it.cell_w);
      m_scr_t_in = 16'(it.y) * 16'(it.cell_h);
      m_ycols_in = 17'(it.y) * 17'(it.cols);
      m_lcr_in   = 21'(it.layer) * 21'(it.cols_rows);
   end

   // ------------------------------------------------------ output stage
   always_comb begin
      logic [18:0] cell_index;
      logic [24:0] bottom;

      cell_index = 19'(mitem_ff.x) + 19'(m_ycols_ff) + 19'(m_lcr_ff);
      bottom     = 25'(m_tex_t_ff) + 25'(mitem_ff.tile_h);

      ov_in      = mv_ff;
      o_slot_in  = {cell_index, 2'b00};
      o_scr_l_in = m_scr_l_ff;
      o_scr_t_in = m_scr_t_ff;
      o_scr_r_in = m_scr_l_ff + 16'(mitem_ff.cell_w);
      o_scr_b_in = m_scr_t_ff + 16'(mitem_ff.cell_h);
      o_tex_l_in = m_tex_l_ff;
      o_tex_t_in = m_tex_t_ff;
      o_tex_r_in = m_tex_l_ff + 16'(mitem_ff.tile_w);
      o_tex_b_in = bottom[24] ? 24'hFF_FFFF : bottom[23:0];
      o_sel_in   = mitem_ff.sel;
      o_alpha_in = mitem_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         mv_ff <= mv_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      mitem_ff   <= mitem_in;
      m_tex_l_ff <= m_tex_l_in;
      m_tex_t_ff <= m_tex_t_in;
      m_scr_l_ff <= m_scr_l_in;
      m_scr_t_ff <= m_scr_t_in;
      m_ycols_ff <= m_ycols_in;
      m_lcr_ff   <= m_lcr_in;
      o_slot_ff  <= o_slot_in;
      o_scr_l_ff <= o_scr_l_in;
      o_scr_t_ff <= o_scr_t_in;
      o_scr_r_ff <= o_scr_r_in;
      o_scr_b_ff <= o_scr_b_in;
      o_tex_l_ff <= o_tex_l_in;
      o_tex_t_ff <= o_tex_t_in;
      o_tex_r_ff <= o_tex_r_in;
      o_tex_b_ff <= o_tex_b_in;
      o_sel_ff   <= o_sel_in;
      o_alpha_ff <= o_alpha_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_vertex_slot   = o_slot_ff;
   assign rsp_screen_left   = o_scr_l_ff;
   assign rsp_screen_top    = o_scr_t_ff;
   assign rsp_screen_right  = o_scr_r_ff;
   assign rsp_screen_bottom = o_scr_b_ff;
   assign rsp_tex_left      = o_tex_l_ff;
   assign rsp_tex_top       = o_tex_t_ff;
   assign rsp_tex_right     = o_tex_r_ff;
   assign rsp_tex_bottom    = o_tex_b_ff;
   assign rsp_tileset_index = o_sel_ff;
   assign rsp_vertex_alpha  = o_alpha_ff;

   // ------------------------------------------------------ assertions
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      dv_ff[0] |-> div_ff[0].divisor != '0)
      else $error("live word entered the divider with a zero divisor");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      dv_ff[DIV_STAGES] |-> div_ff[DIV_STAGES].rem < div_ff[DIV_STAGES].divisor)
      else $error("divider remainder not below the column count");

   a_empty_cell: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_tile_id == '0) |-> ##7 !rsp_valid)
      else $error("empty cell produced a result word");

   a_tex_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_bottom >= rsp_tex_top)
      else $error("texture bottom above texture top");

endmodule

// ----- tb/tile_quad_coordinate_generator_tb.sv -----
`timescale 1ns / 100ps

module tile_quad_coordinate_generator_tb;
   import tqcg_pkg::*;

   localparam int PIPE_LATENCY     = 7;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_PER_PHASE = 550;
   localparam int REMAP_EVERY      = 110;

   typedef struct packed {
      logic [7:0]  cell_x;
      logic [7:0]  cell_y;
      logic [2:0]  layer_number;
      logic [15:0] tile_id;
      logic [7:0]  layer_alpha;
   } cell_word_type;

   typedef struct packed {
      logic [20:0] vertex_slot;
      logic [15:0] screen_left;
      logic [15:0] screen_top;
      logic [15:0] screen_right;
      logic [15:0] screen_bottom;
      logic [15:0] tex_left;
      logic [23:0] tex_top;
      logic [15:0] tex_right;
      logic [23:0] tex_bottom;
      logic [1:0]  tileset_index;
      logic [7:0]  vertex_alpha;
   } quad_type;

   typedef struct packed {
      logic [8:0]             cols;
      logic [8:0]             rows;
      logic [15:0]            cell_size;
      logic [2:0]             count;
      tileset_type [3:0]      sets;
   } map_setup_type;

   typedef enum logic [1:0] {
      ROW_NO_RESULT,
      ROW_TYPED,
      ROW_PREDICTED
   } row_kind_type;

   typedef struct {
      int            setup;
      cell_word_type stim;
      row_kind_type  kind;
      quad_type      quad;
   } dir_row_type;

   localparam quad_type NO_QUAD = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_cell_x = '0;
   logic [7:0]  req_cell_y = '0;
   logic [2:0]  req_layer_number = '0;
   logic [15:0] req_tile_id = '0;
   logic [7:0]  req_layer_alpha = '0;
   logic        rsp_valid;
   logic [20:0] rsp_vertex_slot;
   logic [15:0] rsp_screen_left;
   logic [15:0] rsp_screen_top;
   logic [15:0] rsp_screen_right;
   logic [15:0] rsp_screen_bottom;
   logic [15:0] rsp_tex_left;
   logic [23:0] rsp_tex_top;
   logic [15:0] rsp_tex_right;
   logic [23:0] rsp_tex_bottom;
   logic [1:0]  rsp_tileset_index;
   logic [7:0]  rsp_vertex_alpha;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // predictor's copy of the registers
   logic [8:0]  cfg_cols = 9'd1;
   logic [8:0]  cfg_rows = 9'd1;
   logic [15:0] cfg_cell_size = 16'd257;
   logic [2:0]  cfg_count = 3'd0;
   tileset_type cfg_sets [NUM_ENTRIES] = '{default: '0};

   quad_type    quad_due [$];
   dir_row_type dir_rows [$];
   int          fail_count = 0;
   int          cycle_count = 0;

   tile_quad_coordinate_generator uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_layer_number  (req_layer_number),
      .req_tile_id       (req_tile_id),
      .req_layer_alpha   (req_layer_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_slot   (rsp_vertex_slot),
      .rsp_screen_left   (rsp_screen_left),
      .rsp_screen_top    (rsp_screen_top),
      .rsp_screen_right  (rsp_screen_right),
      .rsp_screen_bottom (rsp_screen_bottom),
      .rsp_tex_left      (rsp_tex_left),
      .rsp_tex_top       (rsp_tex_top),
      .rsp_tex_right     (rsp_tex_right),
      .rsp_tex_bottom    (rsp_tex_bottom),
      .rsp_tileset_index (rsp_tileset_index),
      .rsp_vertex_alpha  (rsp_vertex_alpha),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic bit predict_quad(cell_word_type c, output quad_type q);
      int          n_sets;
      int          sel;
      bit          owned;
      longint unsigned first_id, tcols, tw, th, local_id, col_t, row_t;
      longint unsigned cols, rows, cw, ch, slot, bottom;
      q = '0;
      owned = 1'b0;
      sel = 0;
      if (c.tile_id == 0)
         return 1'b0;
      n_sets = (cfg_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(cfg_count);
      // highest active entry wins, lower entries are never a fallback
      for (int i = n_sets - 1; i >= 0; i--) begin
         if (!owned && cfg_sets[i].first_id <= c.tile_id) begin
            owned = 1'b1;
            sel = i;
         end
      end
      if (!owned)
         return 1'b0;
      first_id = cfg_sets[sel].first_id;
      tcols = cfg_sets[sel].columns;
      tw = cfg_sets[sel].tile_w;
      th = cfg_sets[sel].tile_h;
      if (tcols == 0)
         return 1'b0;
      local_id = c.tile_id - first_id;
      col_t = local_id % tcols;
      row_t = local_id / tcols;
      cols = (cfg_cols > 256) ? 256 : cfg_cols;
      rows = (cfg_rows > 256) ? 256 : cfg_rows;
      cw = cfg_cell_size[7:0];
      ch = cfg_cell_size[15:8];
      // a 3-bit layer can never reach the layer limit, so no clamp is needed
      slot = (c.cell_x + c.cell_y * cols + c.layer_number * cols * rows) * 4;
      bottom = (row_t + 1) * th;
      if (bottom > 64'hFF_FFFF)
         bottom = 64'hFF_FFFF;
      q.vertex_slot   = slot[20:0];
      q.screen_left   = 16'(c.cell_x * cw);
      q.screen_top    = 16'(c.cell_y * ch);
      q.screen_right  = 16'((c.cell_x + 1) * cw);
      q.screen_bottom = 16'((c.cell_y + 1) * ch);
      q.tex_left      = 16'(col_t * tw);
      q.tex_top       = 24'(row_t * th);
      q.tex_right     = 16'((col_t + 1) * tw);
      q.tex_bottom    = bottom[23:0];
      q.tileset_index = sel[1:0];
      q.vertex_alpha  = c.layer_alpha;
      return 1'b1;
   endfunction

   task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      quad_type want;
      if (!reset && rsp_valid) begin
         if (quad_due.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            want = quad_due.pop_front();
            check_field("vertex_slot", 24'(want.vertex_slot), 24'(rsp_vertex_slot));
            check_field("screen_left", 24'(want.screen_left), 24'(rsp_screen_left));
            check_field("screen_top", 24'(want.screen_top), 24'(rsp_screen_top));
            check_field("screen_right", 24'(want.screen_right), 24'(rsp_screen_right));
            check_field("screen_bottom", 24'(want.screen_bottom), 24'(rsp_screen_bottom));
            check_field("tex_left", 24'(want.tex_left), 24'(rsp_tex_left));
            check_field("tex_top", want.tex_top, rsp_tex_top);
            check_field("tex_right", 24'(want.tex_right), 24'(rsp_tex_right));
            check_field("tex_bottom", want.tex_bottom, rsp_tex_bottom);
            check_field("tileset_index", 24'(want.tileset_index), 24'(rsp_tileset_index));
            check_field("vertex_alpha", 24'(want.vertex_alpha), 24'(rsp_vertex_alpha));
         end
      end
   end

   // called just after a rising edge; back-to-back writes go setup after access
   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MAP_COLUMNS:   cfg_cols = value[8:0];
         REG_MAP_ROWS:      cfg_rows = value[8:0];
         REG_MAP_CELL_SIZE: cfg_cell_size = value[15:0];
         REG_TILESET_COUNT: cfg_count = value[2:0];
         default:           cfg_sets[idx - REG_TILESET_0] = value[39:0];
      endcase
   endtask

   task automatic apply_setup(map_setup_type s);
      write_reg(REG_MAP_COLUMNS, 64'(s.cols));
      write_reg(REG_MAP_ROWS, 64'(s.rows));
      write_reg(REG_MAP_CELL_SIZE, 64'(s.cell_size));
      write_reg(REG_TILESET_COUNT, 64'(s.count));
      for (int i = 0; i < NUM_ENTRIES; i++)
         write_reg(reg_index_type'(REG_TILESET_0 + i), 64'(s.sets[i]));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // cells with no result may still be in flight once the queue drains
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (quad_due.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   task automatic send_cell(cell_word_type c, row_kind_type kind, quad_type typed,
                            int idle_pct);
      quad_type q;
      bit       some;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat (($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
            @(posedge clock);
      end
      start <= 1'b1;
      req_cell_x <= c.cell_x;
      req_cell_y <= c.cell_y;
      req_layer_number <= c.layer_number;
      req_tile_id <= c.tile_id;
      req_layer_alpha <= c.layer_alpha;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (kind)
         ROW_NO_RESULT: some = 1'b0;
         ROW_TYPED: begin
            some = 1'b1;
            q = typed;
         end
         default: some = predict_quad(c, q);
      endcase
      if (some)
         quad_due.insert(quad_due.size(), q);
   endtask

   task automatic add_row(int setup, cell_word_type c, row_kind_type kind, quad_type q);
      dir_row_type r;
      r.setup = setup;
      r.stim = c;
      r.kind = kind;
      r.quad = q;
      dir_rows.insert(dir_rows.size(), r);
   endtask

   function automatic logic [8:0] pick_dim();
      case ($urandom_range(9))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd256;
         3:       return 9'h1FF;
         4:       return 9'($urandom);
         default: return 9'($urandom_range(1, 256));
      endcase
   endfunction

   // k 0 and 1 give the top and bottom extremes, the rest are random maps
   task automatic make_setup(int k, output map_setup_type s);
      int unsigned next_id;
      if (k == 0) begin
         s.cols = 9'h1FF;
         s.rows = 9'h1FF;
         s.cell_size = 16'hFFFF;
         s.count = 3'd7;
      end else if (k == 1) begin
         s.cols = 9'd0;
         s.rows = 9'd0;
         s.cell_size = 16'h0000;
         s.count = 3'd1;
      end else begin
         s.cols = pick_dim();
         s.rows = pick_dim();
         s.cell_size = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
         case ($urandom_range(9))
            0:       s.count = 3'd0;
            1:       s.count = 3'($urandom_range(5, 7));
            default: s.count = 3'($urandom_range(1, 4));
         endcase
      end
      next_id = (k == 1) ? 0 : $urandom_range(1, 16);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (k > 1 && $urandom_range(4) == 0) begin
            s.sets[i] = 40'({$urandom, $urandom});
         end else begin
            // well formed: ascending first ids, mostly non-zero column counts
            s.sets[i].first_id = (next_id > 65535) ? 16'hFFFF : 16'(next_id);
            s.sets[i].columns = ($urandom_range(9) == 0 && k > 1) ? 8'd0
                                                                  : 8'($urandom_range(1, 255));
            s.sets[i].tile_w = (k < 2) ? 8'hFF : 8'($urandom);
            s.sets[i].tile_h = (k < 2) ? 8'hFF : 8'($urandom);
            if (k == 1)
               s.sets[i].columns = 8'd1;
            next_id += $urandom_range(1, 16000);
         end
      end
   endtask

   function automatic logic [15:0] pick_tile_id(map_setup_type s);
      int unsigned base, span;
      case ($urandom_range(19))
         0:       return 16'd0;
         1:       return 16'($urandom);
         2:       return 16'hFFFF;
         default: begin
            base = s.sets[$urandom_range(0, NUM_ENTRIES - 1)].first_id;
            span = 65535 - base;
            if ($urandom_range(1) == 0 && span > 600)
               span = 600;
            return 16'(base + $urandom_range(0, span));
         end
      endcase
   endfunction

   initial begin : stimulus
      map_setup_type dir_setup [3];
      map_setup_type cur_setup;
      int            cur_idx;
      cell_word_type c;

      dir_setup[0] = '0;
      dir_setup[0].cols = 9'd1;
      dir_setup[0].rows = 9'd1;
      dir_setup[0].cell_size = 16'd257;

      dir_setup[1].cols = 9'd256;
      dir_setup[1].rows = 9'd256;
      dir_setup[1].cell_size = 16'hFFFF;
      dir_setup[1].count = 3'd4;
      dir_setup[1].sets[0] = '{tile_h: 8'hFF, tile_w: 8'hFF, columns: 8'd1, first_id: 16'd1};
      dir_setup[1].sets[1] = '{tile_h: 8'd3, tile_w: 8'd3, columns: 8'd0, first_id: 16'd100};
      dir_setup[1].sets[2] = '{tile_h: 8'd16, tile_w: 8'd16, columns: 8'd255,
                               first_id: 16'd200};
      dir_setup[1].sets[3] = '{tile_h: 8'd2, tile_w: 8'd1, columns: 8'd7,
                               first_id: 16'hFFFF};

      // oversize map width, zero rows, count above the number of entries
      dir_setup[2].cols = 9'h1FF;
      dir_setup[2].rows = 9'd0;
      dir_setup[2].cell_size = 16'h80FF;
      dir_setup[2].count = 3'd7;
      dir_setup[2].sets[0] = '{tile_h: 8'd5, tile_w: 8'd9, columns: 8'd3, first_id: 16'd10};
      dir_setup[2].sets[1] = '{tile_h: 8'd7, tile_w: 8'd4, columns: 8'd2, first_id: 16'd20};
      dir_setup[2].sets[2] = '{tile_h: 8'd1, tile_w: 8'd1, columns: 8'd1, first_id: 16'd30};
      dir_setup[2].sets[3] = '{tile_h: 8'hFF, tile_w: 8'hFF, columns: 8'd255,
                               first_id: 16'd40};

      add_row(0, '{8'd0, 8'd0, 3'd0, 16'd1, 8'd0}, ROW_NO_RESULT, NO_QUAD);
      add_row(0, '{8'd255, 8'd255, 3'd7, 16'hFFFF, 8'hFF}, ROW_NO_RESULT, NO_QUAD);
      add_row(1, '{8'd3, 8'd4, 3'd1, 16'd0, 8'd9}, ROW_NO_RESULT, NO_QUAD);
      add_row(1, '{8'd0, 8'd0, 3'd0, 16'd1, 8'd0}, ROW_TYPED,
              '{21'd0, 16'd0, 16'd0, 16'd255, 16'd255, 16'd0, 24'd0, 16'd255, 24'd255,
                2'd0, 8'd0});
      add_row(1, '{8'd255, 8'd255, 3'd7, 16'd1, 8'hFF}, ROW_TYPED,
              '{21'd2097148, 16'd65025, 16'd65025, 16'd65280, 16'd65280, 16'd0, 24'd0,
                16'd255, 24'd255, 2'd0, 8'hFF});
      add_row(1, '{8'd17, 8'd3, 3'd2, 16'd99, 8'h11}, ROW_PREDICTED, NO_QUAD);
      // zero columns in the owning entry, and no fall back to entry zero
      add_row(1, '{8'd1, 8'd1, 3'd1, 16'd100, 8'h22}, ROW_NO_RESULT, NO_QUAD);
      add_row(1, '{8'd2, 8'd2, 3'd2, 16'd150, 8'h33}, ROW_NO_RESULT, NO_QUAD);
      add_row(1, '{8'd9, 8'd200, 3'd3, 16'd199, 8'h44}, ROW_PREDICTED, NO_QUAD);
      add_row(1, '{8'd200, 8'd9, 3'd4, 16'd200, 8'h55}, ROW_PREDICTED, NO_QUAD);
      add_row(1, '{8'd128, 8'd1, 3'd5, 16'd454, 8'h66}, ROW_PREDICTED, NO_QUAD);
      add_row(1, '{8'd1, 8'd128, 3'd6, 16'd455, 8'h77}, ROW_PREDICTED, NO_QUAD);
      add_row(1, '{8'd254, 8'd253, 3'd7, 16'hFFFE, 8'h88}, ROW_PREDICTED, NO_QUAD);
      add_row(1, '{8'd0, 8'd0, 3'd0, 16'hFFFF, 8'h5A}, ROW_TYPED,
              '{21'd0, 16'd0, 16'd0, 16'd255, 16'd255, 16'd0, 24'd0, 16'd1, 24'd2,
                2'd3, 8'h5A});
      add_row(1, '{8'd128, 8'd64, 3'd5, 16'h8000, 8'h80}, ROW_PREDICTED, NO_QUAD);
      add_row(2, '{8'd5, 8'd5, 3'd1, 16'd5, 8'h01}, ROW_NO_RESULT, NO_QUAD);
      add_row(2, '{8'd6, 8'd6, 3'd2, 16'd9, 8'h02}, ROW_NO_RESULT, NO_QUAD);
      add_row(2, '{8'd7, 8'd7, 3'd3, 16'd10, 8'h03}, ROW_PREDICTED, NO_QUAD);
      add_row(2, '{8'd255, 8'd255, 3'd7, 16'd25, 8'hAA}, ROW_PREDICTED, NO_QUAD);
      add_row(2, '{8'd100, 8'd50, 3'd4, 16'd45, 8'h55}, ROW_PREDICTED, NO_QUAD);
      add_row(2, '{8'd0, 8'd255, 3'd0, 16'hFFFF, 8'hFE}, ROW_PREDICTED, NO_QUAD);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_idx = 0;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].setup != cur_idx) begin
            wait_idle();
            cur_idx = dir_rows[r].setup;
            apply_setup(dir_setup[cur_idx]);
         end
         send_cell(dir_rows[r].stim, dir_rows[r].kind, dir_rows[r].quad, 27);
      end

      // sender gaps: 27 in a hundred, then 55, then none
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % REMAP_EVERY == 0) begin
               wait_idle();
               make_setup(phase * (RANDOM_PER_PHASE / REMAP_EVERY) + n / REMAP_EVERY,
                          cur_setup);
               apply_setup(cur_setup);
            end
            c.cell_x = 8'($urandom);
            c.cell_y = 8'($urandom);
            c.layer_number = 3'($urandom);
            c.tile_id = pick_tile_id(cur_setup);
            c.layer_alpha = 8'($urandom);
            send_cell(c, ROW_PREDICTED, NO_QUAD, (phase == 0) ? 27 : (phase == 1) ? 55 : 0);
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
